// ===== rtl/core/bsl_pkg.sv =====
// ----------------------------------------------------------------------------
// bsl_pkg
// shared codes, field widths and types of the bounded sequence list
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    // command kinds
    localparam logic [KIND_W-1:0] K_PUSH_BACK  = 3'd0;
    localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] K_POP_BACK   = 3'd2;
    localparam logic [KIND_W-1:0] K_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] K_FIND       = 3'd4;
    localparam logic [KIND_W-1:0] K_DELETE     = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_SC_RD  = 7'b0000100,
        S_SC_CMP = 7'b0001000,
        S_SH_RD  = 7'b0010000,
        S_SH_WR  = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

endpackage

// ===== rtl/core/bsl_if.sv =====
// ----------------------------------------------------------------------------
// bsl_if
// command and response channels of the bounded sequence list
// ----------------------------------------------------------------------------
interface bsl_cmd_if;
    logic                                valid;
    logic                                ready;
    logic        [bsl_pkg::KIND_W-1:0]   kind;
    logic signed [bsl_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bsl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [bsl_pkg::STATUS_W-1:0]   status;
    logic [bsl_pkg::POS_W-1:0]      position;
    logic [bsl_pkg::COUNT_W-1:0]    count;

    modport source (output valid, output status, output position, output count,
                    input ready);
    modport sink   (input valid, input status, input position, input count,
                    output ready);
endinterface

// ===== rtl/core/bsl_ram.sv =====
// ----------------------------------------------------------------------------
// bsl_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bounded_sequence_list.sv =====
// ----------------------------------------------------------------------------
// bounded_sequence_list
// ordered list of up to CAPACITY signed words with push/pop at both ends,
// find and delete-by-value, kept in one ram as a ring
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-----------------------------------
//  i_cmd    | in  | valid / ready | kind (3), value (32, signed)
//  o_rsp    | out | valid / ready | status (2), position (6), count (7)
//
//  push, pop and unused kinds pass through EXEC and RESP, RESP holding while an
//  earlier result waits; the result is registered as the block returns to idle
//  and only then takes a new command; find adds SC_RD and SC_CMP per compared
//  entry, delete SH_RD and SH_WR per entry moved down, both due to the single
//  registered ram read port; reset clears head, count and control only;
//  entries past the count are never read, so the ram needs no clearing pass
//  a new command is taken in idle even while the last result waits on o_rsp
// ----------------------------------------------------------------------------
module bounded_sequence_list #(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bsl_cmd_if.sink   i_cmd,
    bsl_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_X = (IDX_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // logical position to ram address, ring starts at the head
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= CAP_X) begin
            sum = sum - CAP_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    // control state
    bsl_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // working registers of the current command
    logic [bsl_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [WORD_BITS-1:0]         r_word, n_word;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [IDX_W-1:0]             r_pos, n_pos;
    logic [bsl_pkg::STATUS_W-1:0] r_status, n_status;

    // result register
    logic [bsl_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [bsl_pkg::POS_W-1:0]    r_out_pos, n_out_pos;
    logic [bsl_pkg::COUNT_W-1:0]  r_out_count, n_out_count;

    // ram access
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [63:0]      value_ext;
    logic [CNT_W-1:0] idx_nxt;
    logic [IDX_W:0]   head_p1;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] head_dec;
    logic             cmd_xfer;
    logic             out_free;

    bsl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready    = (r_state == bsl_pkg::S_IDLE);
    assign cmd_xfer       = i_cmd.valid && i_cmd.ready;
    assign out_free       = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.count    = r_out_count;

    // sign-extend the 32-bit value, then keep the stored word width
    assign value_ext = {{32{i_cmd.value[31]}}, i_cmd.value};

    assign idx_nxt  = CNT_W'(r_idx) + CNT_W'(1);
    assign head_p1  = {1'b0, r_head} + (IDX_W + 1)'(1);
    assign head_inc = (head_p1 == CAP_X) ? '0 : head_p1[IDX_W-1:0];
    assign head_dec = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - IDX_W'(1);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_kind       = r_kind;
        n_word       = r_word;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = phys(r_head, IDX_W'(r_count));
        ram_wdata    = r_word;
        ram_raddr    = phys(r_head, r_idx);

        // result leaves when the sink takes it
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bsl_pkg::S_IDLE: begin
                if (cmd_xfer) begin
                    n_kind  = i_cmd.kind;
                    n_word  = value_ext[WORD_BITS-1:0];
                    n_state = bsl_pkg::S_EXEC;
                end
            end

            bsl_pkg::S_EXEC: begin
                n_status = bsl_pkg::ST_OK;
                n_pos    = '0;
                n_idx    = '0;
                n_state  = bsl_pkg::S_RESP;
                case (r_kind)
                    bsl_pkg::K_PUSH_BACK: begin
                        if (r_count == CAP_C) begin
                            n_status = bsl_pkg::ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    bsl_pkg::K_PUSH_FRONT: begin
                        if (r_count == CAP_C) begin
                            n_status = bsl_pkg::ST_FULL;
                        end else begin
                            // new front lands one place before the old head
                            ram_we    = 1'b1;
                            ram_waddr = head_dec;
                            n_head    = head_dec;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    bsl_pkg::K_POP_BACK: begin
                        if (r_count == '0) begin
                            n_status = bsl_pkg::ST_EMPTY;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    bsl_pkg::K_POP_FRONT: begin
                        if (r_count == '0) begin
                            n_status = bsl_pkg::ST_EMPTY;
                        end else begin
                            n_head  = head_inc;
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    bsl_pkg::K_FIND, bsl_pkg::K_DELETE: begin
                        // empty list counts as value absent
                        if (r_count == '0) begin
                            n_status = bsl_pkg::ST_ABSENT;
                        end else begin
                            n_state = bsl_pkg::S_SC_RD;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            bsl_pkg::S_SC_RD: begin
                // read of entry r_idx issued through ram_raddr
                n_state = bsl_pkg::S_SC_CMP;
            end

            bsl_pkg::S_SC_CMP: begin
                if (ram_rdata == r_word) begin
                    n_pos = r_idx;
                    if (r_kind == bsl_pkg::K_DELETE) begin
                        if (idx_nxt < r_count) begin
                            n_state = bsl_pkg::S_SH_RD;
                        end else begin
                            // last live entry, nothing to move
                            n_count = r_count - CNT_W'(1);
                            n_state = bsl_pkg::S_RESP;
                        end
                    end else begin
                        n_state = bsl_pkg::S_RESP;
                    end
                end else if (idx_nxt == r_count) begin
                    n_status = bsl_pkg::ST_ABSENT;
                    n_state  = bsl_pkg::S_RESP;
                end else begin
                    n_idx   = IDX_W'(idx_nxt);
                    n_state = bsl_pkg::S_SC_RD;
                end
            end

            bsl_pkg::S_SH_RD: begin
                ram_raddr = phys(r_head, IDX_W'(idx_nxt));
                n_state   = bsl_pkg::S_SH_WR;
            end

            bsl_pkg::S_SH_WR: begin
                // entry r_idx+1 moves down to r_idx
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_idx);
                ram_wdata = ram_rdata;
                n_idx     = IDX_W'(idx_nxt);
                if (({1'b0, idx_nxt} + (CNT_W + 1)'(1)) < {1'b0, r_count}) begin
                    n_state = bsl_pkg::S_SH_RD;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = bsl_pkg::S_RESP;
                end
            end

            bsl_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = bsl_pkg::POS_W'(r_pos);
                    n_out_count  = bsl_pkg::COUNT_W'(r_count);
                    n_state      = bsl_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bsl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsl_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_word       <= n_word;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

endmodule

// ===== rtl/core/bsl_chk.sv =====
// ----------------------------------------------------------------------------
// bsl_chk
// port-level checks of the bounded sequence list, bound to the top level
// ----------------------------------------------------------------------------
module bsl_chk #(
    parameter int CAPACITY = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [bsl_pkg::STATUS_W-1:0]   i_rsp_status,
    input logic [bsl_pkg::POS_W-1:0]      i_rsp_position,
    input logic [bsl_pkg::COUNT_W-1:0]    i_rsp_count
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_position) && $stable(i_rsp_count))
        else $error("response changed while stalled");

    // full is only reported at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == bsl_pkg::ST_FULL
            |-> i_rsp_count == bsl_pkg::COUNT_W'(CAPACITY) && i_rsp_position == '0)
        else $error("full status with count below capacity");

    // empty is only reported on an empty list
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == bsl_pkg::ST_EMPTY
            |-> i_rsp_count == '0 && i_rsp_position == '0)
        else $error("empty status with live entries");

    // absent value gives position zero
    a_absent_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == bsl_pkg::ST_ABSENT |-> i_rsp_position == '0)
        else $error("absent value with nonzero position");

endmodule

bind bounded_sequence_list bsl_chk #(
    .CAPACITY (CAPACITY)
) u_bsl_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_position (o_rsp.position),
    .i_rsp_count    (o_rsp.count)
);
